// File: sv/srt_pkg.sv
`timescale 1ns / 1ps

package srt_pkg;

  localparam int MAX_SYMBOLS_DEF = 16;
  localparam int VALUE_BITS_DEF  = 32;
  localparam int CFG_IDX_BITS    = 2;
  localparam int CFG_DATA_BITS   = 64;
  localparam int CHAR_BITS       = 8;
  localparam int RADIX_BITS      = 5;
  localparam int TAB_SIZE        = 16;
  localparam int CHUNK_BITS      = 8;

  localparam logic [CHAR_BITS-1:0] SYM_PLUS  = 8'h2B;
  localparam logic [CHAR_BITS-1:0] SYM_MINUS = 8'h2D;

  // "01234567" and "89" in the low bytes
  localparam logic [RADIX_BITS-1:0]    RADIX_RST    = 5'd10;
  localparam logic [CFG_DATA_BITS-1:0] SYM_LOW_RST  = 64'h3736_3534_3332_3130;
  localparam logic [CFG_DATA_BITS-1:0] SYM_HIGH_RST = 64'h0000_0000_0000_3938;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_RADIX    = 2'd0,
    REG_SYM_LOW  = 2'd1,
    REG_SYM_HIGH = 2'd2
  } cfg_reg_t;

  // datapath operation of one microcode step
  typedef enum logic [3:0] {
    OP_NOP     = 4'd0,
    OP_LOAD    = 4'd1,
    OP_DIV     = 4'd2,
    OP_MINUS   = 4'd3,
    OP_POP     = 4'd4,
    OP_DIGIT   = 4'd5,
    OP_ZERO    = 4'd6,
    OP_CHK_CLR = 4'd7,
    OP_CHK     = 4'd8,
    OP_CHK_SET = 4'd9
  } op_t;

  // branch condition of one microcode step
  typedef enum logic [3:0] {
    C_ALWAYS      = 4'd0,
    C_DIRTY       = 4'd1,
    C_ACCEPT      = 4'd2,
    C_BAD         = 4'd3,
    C_MAG_ZERO    = 4'd4,
    C_DIV_LAST    = 4'd5,
    C_NEG         = 4'd6,
    C_OUT_FREE    = 4'd7,
    C_STACK_EMPTY = 4'd8,
    C_CHK_LAST    = 4'd9
  } cond_t;

  typedef logic [3:0] upc_t;

  localparam upc_t S_IDLE    = 4'd0;
  localparam upc_t S_TAKE    = 4'd1;
  localparam upc_t S_SCREEN  = 4'd2;
  localparam upc_t S_ZTEST   = 4'd3;
  localparam upc_t S_DIV     = 4'd4;
  localparam upc_t S_MORE    = 4'd5;
  localparam upc_t S_SIGN    = 4'd6;
  localparam upc_t S_MINUS   = 4'd7;
  localparam upc_t S_POP     = 4'd8;
  localparam upc_t S_DIGIT   = 4'd9;
  localparam upc_t S_NEXT    = 4'd10;
  localparam upc_t S_ZERO    = 4'd11;
  localparam upc_t S_CHK_CLR = 4'd12;
  localparam upc_t S_CHK     = 4'd13;
  localparam upc_t S_CHK_SET = 4'd14;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    upc_t  jt;   // taken when the condition holds
    upc_t  jf;   // taken otherwise
  } ucw_t;

  typedef struct packed {
    logic dirty;
    logic accept;
    logic bad;
    logic mag_zero;
    logic div_last;
    logic neg;
    logic out_free;
    logic stack_empty;
    logic chk_last;
  } flags_t;

  function automatic ucw_t srt_ucode(input upc_t pc);
    ucw_t w;
    case (pc)
      S_IDLE:    w = '{OP_NOP,     C_DIRTY,       S_CHK_CLR, S_TAKE};
      S_TAKE:    w = '{OP_LOAD,    C_ACCEPT,      S_SCREEN,  S_IDLE};
      S_SCREEN:  w = '{OP_NOP,     C_BAD,         S_IDLE,    S_ZTEST};
      S_ZTEST:   w = '{OP_NOP,     C_MAG_ZERO,    S_ZERO,    S_DIV};
      S_DIV:     w = '{OP_DIV,     C_DIV_LAST,    S_MORE,    S_DIV};
      S_MORE:    w = '{OP_NOP,     C_MAG_ZERO,    S_SIGN,    S_DIV};
      S_SIGN:    w = '{OP_NOP,     C_NEG,         S_MINUS,   S_POP};
      S_MINUS:   w = '{OP_MINUS,   C_OUT_FREE,    S_POP,     S_MINUS};
      S_POP:     w = '{OP_POP,     C_ALWAYS,      S_DIGIT,   S_DIGIT};
      S_DIGIT:   w = '{OP_DIGIT,   C_OUT_FREE,    S_NEXT,    S_DIGIT};
      S_NEXT:    w = '{OP_NOP,     C_STACK_EMPTY, S_IDLE,    S_POP};
      S_ZERO:    w = '{OP_ZERO,    C_OUT_FREE,    S_IDLE,    S_ZERO};
      S_CHK_CLR: w = '{OP_CHK_CLR, C_ALWAYS,      S_CHK,     S_CHK};
      S_CHK:     w = '{OP_CHK,     C_CHK_LAST,    S_CHK_SET, S_CHK};
      S_CHK_SET: w = '{OP_CHK_SET, C_ALWAYS,      S_IDLE,    S_IDLE};
      default:   w = '{OP_NOP,     C_ALWAYS,      S_IDLE,    S_IDLE};
    endcase
    return w;
  endfunction

endpackage

// File: sv/srt_if.sv
`timescale 1ns / 1ps

interface srt_in_if import srt_pkg::*; #(
  parameter int VALUE_BITS = VALUE_BITS_DEF
) ();
  logic                         valid;
  logic                         ready;
  logic signed [VALUE_BITS-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface srt_out_if import srt_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CHAR_BITS-1:0] character;
  logic                 last;

  modport source (output valid, output character, output last, input ready);
  modport sink   (input valid, input character, input last, output ready);
endinterface

interface srt_cfg_if import srt_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [CFG_IDX_BITS-1:0]  index;
  logic [CFG_DATA_BITS-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// File: sv/srt_seq.sv
`timescale 1ns / 1ps

module srt_seq import srt_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  flags_t flags,
  output ucw_t   ctl
);

  upc_t pc_r;
  upc_t pc_nxt;
  logic take;

  assign ctl = srt_ucode(pc_r);

  always_comb begin
    case (ctl.cond)
      C_ALWAYS:      take = 1'b1;
      C_DIRTY:       take = flags.dirty;
      C_ACCEPT:      take = flags.accept;
      C_BAD:         take = flags.bad;
      C_MAG_ZERO:    take = flags.mag_zero;
      C_DIV_LAST:    take = flags.div_last;
      C_NEG:         take = flags.neg;
      C_OUT_FREE:    take = flags.out_free;
      C_STACK_EMPTY: take = flags.stack_empty;
      C_CHK_LAST:    take = flags.chk_last;
      default:       take = 1'b1;
    endcase
    pc_nxt = take ? ctl.jt : ctl.jf;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= S_IDLE;
    end else begin
      pc_r <= pc_nxt;
    end
  end

endmodule

// File: sv/signed_radix_to_text.sv
`timescale 1ns / 1ps

// Signed integer to text in a programmable radix.
// in_ch carries one signed value per beat. out_ch returns its text one
// character per beat, most significant digit first, a minus sign ahead of
// negative values, with last set on the final character. cfg_ch writes the
// radix (index 0) and the two 8-symbol digit tables (indexes 1 and 2); it
// is always ready and is meant to be used only while the block is idle.
// A bad table (radix below 2 or above MAX_SYMBOLS, a '+' or '-' symbol, or
// a repeated symbol) makes the block take values and return nothing.
// The block works on one value at a time. Each of its D digits takes
// C = ceil(VALUE_BITS/8) steps of the shared radix divider, which retires
// 8 dividend bits a cycle; decimal 32-bit values have D <= 10 and C = 4.
// The first character, a minus sign or the top digit, is registered only
// after every digit has been divided out.
// Reset and every config write trigger a table check (clear, one step per
// symbol slot, set), during which in_ch is held not ready.
// A stalled receiver holds the character in the output register; the block
// keeps its place in the program until the beat is taken, and the next value
// may be accepted while the final character still waits.
module signed_radix_to_text import srt_pkg::*; #(
  parameter int MAX_SYMBOLS = MAX_SYMBOLS_DEF,
  parameter int VALUE_BITS  = VALUE_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  srt_in_if.sink       in_ch,
  srt_out_if.source    out_ch,
  srt_cfg_if.sink      cfg_ch
);

  localparam int NCH = (VALUE_BITS + CHUNK_BITS - 1) / CHUNK_BITS;
  localparam int QW  = NCH * CHUNK_BITS;
  localparam int CCW = (NCH > 1) ? $clog2(NCH) : 1;
  localparam int DW  = $clog2(MAX_SYMBOLS);
  localparam int AW  = $clog2(VALUE_BITS);
  localparam int SPW = $clog2(VALUE_BITS + 1);
  localparam int TW  = RADIX_BITS + 1;

  // configuration
  logic [RADIX_BITS-1:0]    radix_r;
  logic [CFG_DATA_BITS-1:0] sym_low_r;
  logic [CFG_DATA_BITS-1:0] sym_high_r;
  logic                     dirty_r;
  logic                     ok_r;
  logic                     bad_r;
  logic [DW-1:0]            ci_r;
  logic [CHAR_BITS-1:0]     sym_w [TAB_SIZE];
  logic [CHAR_BITS-1:0]     sym_i;
  logic                     chk_hit;
  logic                     cfg_we;

  // datapath
  logic [QW-1:0]            mag_r;
  logic                     neg_r;
  logic [DW-1:0]            rem_r;
  logic [CCW-1:0]           cc_r;
  logic [SPW-1:0]           sp_r;
  logic [DW-1:0]            mem [VALUE_BITS];
  logic [DW-1:0]            dig_q_r;
  logic [VALUE_BITS-1:0]    value_u;
  logic [VALUE_BITS-1:0]    mag_ld;
  logic [CHUNK_BITS-1:0]    chunk;
  logic [CHUNK_BITS-1:0]    q_v;
  logic [DW-1:0]            rem_v;
  logic [TW-1:0]            t_v;
  logic                     div_last;

  // output register
  logic                     out_valid_r;
  logic [CHAR_BITS-1:0]     out_char_r;
  logic                     out_last_r;
  logic                     out_free;
  logic                     emit;
  logic [CHAR_BITS-1:0]     emit_char;
  logic                     emit_last;

  flags_t flags;
  ucw_t   ctl;

  srt_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .flags (flags),
    .ctl   (ctl)
  );

  // Symbol table view of the two config words.
  always_comb begin
    for (int k = 0; k < TAB_SIZE / 2; k++) begin
      sym_w[k]                = sym_low_r[CHAR_BITS*k +: CHAR_BITS];
      sym_w[k + TAB_SIZE / 2] = sym_high_r[CHAR_BITS*k +: CHAR_BITS];
    end
  end

  assign cfg_ch.ready = 1'b1;
  assign cfg_we       = cfg_ch.valid;

  // Table check for symbol ci: a sign symbol, or a later symbol in use
  // that repeats it, marks the table bad.
  always_comb begin
    sym_i   = sym_w[4'(ci_r)];
    chk_hit = 1'b0;
    if (5'(ci_r) < radix_r) begin
      if (sym_i == SYM_PLUS || sym_i == SYM_MINUS) begin
        chk_hit = 1'b1;
      end
      for (int j = 0; j < MAX_SYMBOLS; j++) begin
        if (5'(j) > 5'(ci_r) && 5'(j) < radix_r && sym_w[j] == sym_i) begin
          chk_hit = 1'b1;
        end
      end
    end
  end

  // Magnitude of the incoming value; the most negative value fits unsigned.
  assign value_u = in_ch.value;
  assign mag_ld  = value_u[VALUE_BITS-1] ? VALUE_BITS'(~value_u + 1'b1) : value_u;

  // Divider: retire the top byte of the dividend per cycle, restoring one
  // bit at a time against the radix. Quotient bits shift in at the bottom.
  assign chunk = mag_r[QW-1 -: CHUNK_BITS];
  always_comb begin
    rem_v = rem_r;
    q_v   = '0;
    t_v   = '0;
    for (int b = CHUNK_BITS - 1; b >= 0; b--) begin
      t_v = TW'({rem_v, chunk[b]});
      if (t_v >= TW'(radix_r)) begin
        q_v[b] = 1'b1;
        rem_v  = DW'(t_v - TW'(radix_r));
      end else begin
        rem_v  = DW'(t_v);
      end
    end
  end

  assign div_last = (cc_r == CCW'(NCH - 1));

  assign in_ch.ready = (ctl.op == OP_LOAD) && !dirty_r && !cfg_ch.valid;

  assign out_free = !out_valid_r || out_ch.ready;

  // Character for the current emit step.
  always_comb begin
    emit      = 1'b0;
    emit_char = sym_w[4'(dig_q_r)];
    emit_last = 1'b0;
    case (ctl.op)
      OP_MINUS: begin
        emit      = out_free;
        emit_char = SYM_MINUS;
      end
      OP_DIGIT: begin
        emit      = out_free;
        emit_last = (sp_r == '0);
      end
      OP_ZERO: begin
        emit      = out_free;
        emit_char = sym_w[0];
        emit_last = 1'b1;
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  always_comb begin
    flags.dirty       = dirty_r;
    flags.accept      = in_ch.valid && in_ch.ready;
    flags.bad         = !ok_r;
    flags.mag_zero    = (mag_r == '0);
    flags.div_last    = div_last;
    flags.neg         = neg_r;
    flags.out_free    = out_free;
    flags.stack_empty = (sp_r == '0);
    flags.chk_last    = (ci_r == DW'(MAX_SYMBOLS - 1));
  end

  // Config registers and table status.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_r    <= RADIX_RST;
      sym_low_r  <= SYM_LOW_RST;
      sym_high_r <= SYM_HIGH_RST;
      dirty_r    <= 1'b1;
      ok_r       <= 1'b0;
      bad_r      <= 1'b0;
      ci_r       <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_ch.index)
          REG_RADIX:    radix_r    <= cfg_ch.data[RADIX_BITS-1:0];
          REG_SYM_LOW:  sym_low_r  <= cfg_ch.data;
          REG_SYM_HIGH: sym_high_r <= cfg_ch.data;
          default:      radix_r    <= radix_r;
        endcase
      end
      // a write always wins over the clear so the check reruns
      if (cfg_we) begin
        dirty_r <= 1'b1;
      end else if (ctl.op == OP_CHK_CLR) begin
        dirty_r <= 1'b0;
      end
      case (ctl.op)
        OP_CHK_CLR: begin
          bad_r <= 1'b0;
          ci_r  <= '0;
        end
        OP_CHK: begin
          bad_r <= bad_r | chk_hit;
          ci_r  <= ci_r + 1'b1;
        end
        OP_CHK_SET: begin
          ok_r <= !bad_r && radix_r >= RADIX_BITS'(2)
                  && radix_r <= RADIX_BITS'(MAX_SYMBOLS);
        end
        default: begin
          ok_r <= ok_r;
        end
      endcase
    end
  end

  // Remainder, chunk counter, digit stack pointer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r <= '0;
      cc_r  <= '0;
      sp_r  <= '0;
    end else begin
      case (ctl.op)
        OP_LOAD: begin
          rem_r <= '0;
          cc_r  <= '0;
          sp_r  <= '0;
        end
        OP_DIV: begin
          if (div_last) begin
            rem_r <= '0;
            cc_r  <= '0;
            sp_r  <= sp_r + 1'b1;
          end else begin
            rem_r <= rem_v;
            cc_r  <= cc_r + 1'b1;
          end
        end
        OP_POP: begin
          sp_r <= sp_r - 1'b1;
        end
        default: begin
          sp_r <= sp_r;
        end
      endcase
    end
  end

  // Payload registers: no reset.
  always_ff @(posedge clk) begin
    if (ctl.op == OP_LOAD && in_ch.valid && in_ch.ready) begin
      mag_r <= QW'(mag_ld);
      neg_r <= value_u[VALUE_BITS-1];
    end else if (ctl.op == OP_DIV) begin
      if (NCH > 1) begin
        mag_r <= {mag_r[QW-CHUNK_BITS-1:0], q_v};
      end else begin
        mag_r <= QW'(q_v);
      end
    end
  end

  // Digit stack: push the remainder of each division, pop MSD first.
  always_ff @(posedge clk) begin
    if (ctl.op == OP_DIV && div_last) begin
      mem[sp_r[AW-1:0]] <= rem_v;
    end
    if (ctl.op == OP_POP) begin
      dig_q_r <= mem[AW'(sp_r - 1'b1)];
    end
  end

  // Output register: hold until taken, drop valid when drained.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_char_r <= emit_char;
      out_last_r <= emit_last;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.character = out_char_r;
  assign out_ch.last      = out_last_r;

  // The digit stack never grows past one entry per value bit.
  assert property (@(posedge clk) disable iff (!rst_n)
    sp_r <= SPW'(VALUE_BITS))
    else $error("digit stack overflow");

  // Division only runs on a table that passed the check.
  assert property (@(posedge clk) disable iff (!rst_n)
    ctl.op == OP_DIV |-> ok_r)
    else $error("division started on a bad table");

  // Every value starts with an empty digit stack.
  assert property (@(posedge clk) disable iff (!rst_n)
    ctl.op == OP_LOAD |-> sp_r == '0)
    else $error("digit stack not drained");

  // No value is taken while the table check is pending.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready |-> !dirty_r && !cfg_ch.valid)
    else $error("value accepted during table check");

endmodule
